// ----- rtl/core/ssrg_pkg.sv -----
// Shared types and constants for the smoothstep ramp generator.
// Used by the controller, the datapath and the top level; no dependencies.
package ssrg_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 24;

  // Timing registers are fixed at 32 bits, so the divisor is too.
  localparam int TIME_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_DATA_W   = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_VALUE = 2'd0,
    REG_END_VALUE   = 2'd1,
    REG_DURATION    = 2'd2,
    REG_TICK_PERIOD = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_T,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV_P,
    ST_MUL_P2,
    ST_MUL_P3,
    ST_MUL_S,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic edge_err;
    logic div_t_start;
    logic div_step;
    logic load_total;
    logic exec_update;
    logic reach_end;
    logic div_p_start;
    logic mul_step;
    logic mul_p2_start;
    logic mul_p3_start;
    logic mul_s_start;
    logic add_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rise;
    logic timing_bad;
    logic running;
    logic reached;
    logic unit_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/ssrg_ctrl.sv -----
// Sequencer for the smoothstep ramp generator: walks one request through
// edge check, divisions and multiplications. Depends on ssrg_pkg.
module ssrg_ctrl
  import ssrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        if (status.rise && !status.timing_bad) state_next = ST_DIV_T;
        else state_next = ST_UPDATE;
      end
      ST_DIV_T: begin
        if (status.unit_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!status.running || status.reached) state_next = ST_FINISH;
        else state_next = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (status.unit_done) state_next = ST_MUL_P2;
      end
      ST_MUL_P2: begin
        if (status.unit_done) state_next = ST_MUL_P3;
      end
      ST_MUL_P3: begin
        if (status.unit_done) state_next = ST_MUL_S;
      end
      ST_MUL_S: begin
        if (status.unit_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_START: begin
        cmd.edge_err    = status.rise && status.timing_bad;
        cmd.div_t_start = status.rise && !status.timing_bad;
      end
      ST_DIV_T: begin
        cmd.div_step   = !status.unit_done;
        cmd.load_total = status.unit_done;
      end
      ST_UPDATE: cmd.exec_update = 1'b1;
      ST_CHECK: begin
        cmd.reach_end   = status.running && status.reached;
        cmd.div_p_start = status.running && !status.reached;
      end
      ST_DIV_P: begin
        cmd.div_step     = !status.unit_done;
        cmd.mul_p2_start = status.unit_done;
      end
      ST_MUL_P2: begin
        cmd.mul_step     = !status.unit_done;
        cmd.mul_p3_start = status.unit_done;
      end
      ST_MUL_P3: begin
        cmd.mul_step    = !status.unit_done;
        cmd.mul_s_start = status.unit_done;
      end
      ST_MUL_S: begin
        cmd.mul_step = !status.unit_done;
        cmd.add_step = status.unit_done;
      end
      ST_FINISH: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/ssrg_datapath.sv -----
// Datapath of the smoothstep ramp generator: configuration registers, ramp
// state, a shared restoring divider, a shift-add multiplier and the output
// register. Depends on ssrg_pkg; sequenced by ssrg_ctrl.
module ssrg_datapath
  import ssrg_pkg::*;
#(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CFG_W         = (VALUE_WIDTH > TIME_W) ? VALUE_WIDTH : TIME_W,
  parameter int OUT_W         = ((VALUE_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   execute,
  input  logic                   tick,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_W-1:0]       m_tdata
);

  localparam int VW        = VALUE_WIDTH;
  localparam int CW        = COUNT_WIDTH;
  localparam int F         = FRACTION_BITS;
  localparam int DVD_W     = (CW + F > TIME_W) ? CW + F : TIME_W;
  localparam int MCAND_W   = (VW + 1 > F) ? VW + 1 : F;
  localparam int MPLR_W    = F + 2;
  localparam int PROD_W    = MCAND_W + MPLR_W;
  localparam int MAX_STEPS = (DVD_W > MPLR_W) ? DVD_W : MPLR_W;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  // Configuration registers.
  logic [VW-1:0]     start_value, end_value;
  logic [TIME_W-1:0] duration_ms, tick_period_ms;

  // Request and ramp state.
  logic          in_execute, in_tick;
  logic          last_execute, running, stored_error;
  logic          err, busy, done;
  logic [CW-1:0] elapsed_count, total_count;
  logic [VW:0]   span;
  logic [VW-1:0] held_value;

  // Serial arithmetic.
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   quo;
  logic [TIME_W-1:0]  rem, dsor;
  logic [PROD_W-1:0]  acc;
  logic [MCAND_W-1:0] mcand;
  logic [F-1:0]       p, p2;

  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  logic [TIME_W:0]    div_shift, div_diff;
  logic               div_ge;
  logic [MCAND_W:0]   mul_sum;
  logic [CW-1:0]      quo_count;
  logic [F-1:0]       prod_frac;
  logic [MPLR_W-1:0]  s_weight;
  logic [VW:0]        span_mag;
  logic [VW-1:0]      step_mag;

  always_comb begin
    div_shift = {rem, quo[DVD_W-1]};
    div_diff  = div_shift - {1'b0, dsor};
    div_ge    = (div_shift >= {1'b0, dsor});
    mul_sum   = {1'b0, acc[PROD_W-1 -: MCAND_W]} + (acc[0] ? {1'b0, mcand} : '0);
    quo_count = quo[CW-1:0];
    prod_frac = acc[F +: F];
    // 3*p2 - 2*p3, with p3 taken from the finished product.
    s_weight  = (MPLR_W'(p2) << 1) + MPLR_W'(p2) - (MPLR_W'(prod_frac) << 1);
    span_mag  = span[VW] ? (~span + 1'b1) : span;
    step_mag  = acc[F +: VW];
  end

  always_comb begin
    status.rise       = in_execute && !last_execute;
    status.timing_bad = (duration_ms == '0) || (tick_period_ms == '0);
    status.running    = running;
    status.reached    = (elapsed_count >= total_count);
    status.unit_done  = (cnt == '0);
    status.out_free   = !out_valid || m_tready;
  end

  // Control and ramp state.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value    <= '0;
      end_value      <= '0;
      duration_ms    <= '0;
      tick_period_ms <= '0;
      last_execute   <= 1'b0;
      running        <= 1'b0;
      stored_error   <= 1'b0;
      elapsed_count  <= '0;
      total_count    <= '0;
      span           <= '0;
      held_value     <= '0;
      cnt            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_VALUE: start_value    <= cfg_data[VW-1:0];
          REG_END_VALUE:   end_value      <= cfg_data[VW-1:0];
          REG_DURATION:    duration_ms    <= cfg_data[TIME_W-1:0];
          REG_TICK_PERIOD: tick_period_ms <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      if (cmd.edge_err) begin
        stored_error <= 1'b1;
        running      <= 1'b0;
      end
      if (cmd.div_t_start) begin
        stored_error <= 1'b0;
        cnt          <= CNT_W'(DVD_W);
      end
      if (cmd.div_p_start) cnt <= CNT_W'(DVD_W);
      if (cmd.mul_p2_start || cmd.mul_p3_start || cmd.mul_s_start) begin
        cnt <= CNT_W'(MPLR_W);
      end
      if (cmd.div_step || cmd.mul_step) cnt <= cnt - 1'b1;

      if (cmd.load_total) begin
        running       <= 1'b1;
        elapsed_count <= '0;
        total_count   <= (quo_count == '0) ? CW'(1) : quo_count;
        span          <= {end_value[VW-1], end_value} - {start_value[VW-1], start_value};
        held_value    <= start_value;
      end

      if (cmd.exec_update) begin
        if (in_execute) begin
          if (running && in_tick && (elapsed_count < total_count)) begin
            elapsed_count <= elapsed_count + 1'b1;
          end
        end else begin
          running       <= 1'b0;
          elapsed_count <= '0;
          total_count   <= '0;
          stored_error  <= 1'b0;
        end
      end

      if (cmd.reach_end) begin
        held_value <= end_value;
        running    <= 1'b0;
      end

      if (cmd.add_step) begin
        held_value <= span[VW] ? (start_value - step_mag) : (start_value + step_mag);
      end

      if (cmd.out_load) begin
        last_execute <= in_execute;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-request payload and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      in_execute <= execute;
      in_tick    <= tick;
      err        <= stored_error;
      busy       <= 1'b0;
      done       <= 1'b0;
    end
    if (cmd.edge_err) err <= 1'b1;
    if (cmd.exec_update && in_execute) begin
      if (running) busy <= 1'b1;
      else if (!err) done <= 1'b1;
    end
    if (cmd.reach_end) done <= 1'b1;

    if (cmd.div_t_start) begin
      quo  <= DVD_W'(duration_ms);
      dsor <= tick_period_ms;
      rem  <= '0;
    end
    if (cmd.div_p_start) begin
      quo  <= DVD_W'(elapsed_count) << F;
      dsor <= TIME_W'(total_count);
      rem  <= '0;
    end
    if (cmd.div_step) begin
      rem <= div_ge ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
      quo <= {quo[DVD_W-2:0], div_ge};
    end

    if (cmd.mul_p2_start) begin
      p     <= quo[F-1:0];
      mcand <= MCAND_W'(quo[F-1:0]);
      acc   <= PROD_W'(quo[F-1:0]);
    end
    if (cmd.mul_p3_start) begin
      p2    <= prod_frac;
      mcand <= MCAND_W'(prod_frac);
      acc   <= PROD_W'(p);
    end
    if (cmd.mul_s_start) begin
      mcand <= MCAND_W'(span_mag);
      acc   <= PROD_W'(s_weight);
    end
    if (cmd.mul_step) begin
      acc <= {mul_sum, acc[MPLR_W-1:1]};
    end

    if (cmd.out_load) begin
      out_data <= OUT_W'({stored_error, err, done, busy, held_value});
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- rtl/core/smoothstep_ramp_generator_top.sv -----
// Smoothstep ramp generator. Each request carries an execute level and a
// tick strobe and returns one result: the ramp value, busy, done, error and
// the stored error code. A rising edge of execute checks the timing
// registers, divides duration by tick period to get the tick total and
// starts from start_value; each tick moves the output along
// start + (end - start) * (3p^2 - 2p^3). A result needs no arithmetic when
// no interpolation is needed, a division and three multiplications when a
// new point is computed and one more division when a ramp also starts.
// The next request is taken in the cycle after its result is loaded, so
// requests do not overlap. The time is set by the one-bit-per-cycle
// divider and the shift-add multiplier, which all steps share. A finished
// result waits in the output register while the next request is taken.
// Depends on ssrg_pkg, ssrg_ctrl and ssrg_datapath.
module smoothstep_ramp_generator_top
  import ssrg_pkg::*;
#(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CFG_W         = (VALUE_WIDTH > TIME_W) ? VALUE_WIDTH : TIME_W,
  parameter int OUT_W         = ((VALUE_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // execute, tick, zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // ramp_value, busy_res, done_res,
                                            // error, error_code, zero fill
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ssrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssrg_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .CFG_W         (CFG_W),
    .OUT_W         (OUT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .execute   (s_tdata[0]),
    .tick      (s_tdata[1]),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule
